FILE: sv/icpne_pkg.sv
// shared types, constants and step table of the icp normal-equation accumulator
package icpne_pkg;

   // fixed field widths
   localparam int COORD_BITS = 24;
   localparam int CSR_W      = 60;
   localparam int CSR_IDX_W  = 3;
   localparam int IDX_W      = 5;
   localparam int VAL_W      = 64;

   // parameter defaults
   localparam int ROT_FRAC_BITS_DEF = 18;
   localparam int ACC_BITS_DEF      = 64;
   localparam int MAX_POINTS_DEF    = 65536;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROT0   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT1   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT2   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFTX = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFTY = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFTZ = 3'd5;

   // result entries
   localparam int ACC_DEPTH = 28;
   localparam logic [IDX_W-1:0] ENTRY_COUNT = 5'd28;

   // accumulate steps per matched point
   localparam int ACC_STEPS = 30;

   // operand selects
   localparam logic [2:0] OP_PW0 = 3'd0;
   localparam logic [2:0] OP_PW1 = 3'd1;
   localparam logic [2:0] OP_PW2 = 3'd2;
   localparam logic [2:0] OP_R0  = 3'd3;
   localparam logic [2:0] OP_R1  = 3'd4;
   localparam logic [2:0] OP_R2  = 3'd5;
   localparam logic [2:0] OP_ONE = 3'd6;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] body_x;
      logic signed [COORD_BITS-1:0] body_y;
      logic signed [COORD_BITS-1:0] body_z;
      logic                         neighbor_found;
      logic signed [COORD_BITS-1:0] nbr_x;
      logic signed [COORD_BITS-1:0] nbr_y;
      logic signed [COORD_BITS-1:0] nbr_z;
      logic                         last_point;
   } req_payload_type;

   typedef struct packed {
      logic        [IDX_W-1:0] entry_index;
      logic signed [VAL_W-1:0] entry_value;
      logic                    final_entry;
   } rsp_payload_type;

   typedef struct packed {
      logic [IDX_W-1:0] dst;
      logic [2:0]       sel_a;
      logic [2:0]       sel_b;
      logic             neg;
   } ucode_type;

   // one nonzero jacobian product per step, in accumulation order
   function automatic ucode_type step_code(input logic [IDX_W-1:0] step);
      ucode_type uc;
      case (step)
         5'd0:    uc = '{5'd0,  OP_ONE, OP_ONE, 1'b0};
         5'd1:    uc = '{5'd4,  OP_PW2, OP_ONE, 1'b0};
         5'd2:    uc = '{5'd5,  OP_PW1, OP_ONE, 1'b1};
         5'd3:    uc = '{5'd6,  OP_ONE, OP_ONE, 1'b0};
         5'd4:    uc = '{5'd8,  OP_PW2, OP_ONE, 1'b1};
         5'd5:    uc = '{5'd10, OP_PW0, OP_ONE, 1'b0};
         5'd6:    uc = '{5'd11, OP_ONE, OP_ONE, 1'b0};
         5'd7:    uc = '{5'd12, OP_PW1, OP_ONE, 1'b0};
         5'd8:    uc = '{5'd13, OP_PW0, OP_ONE, 1'b1};
         5'd9:    uc = '{5'd15, OP_PW2, OP_PW2, 1'b0};
         5'd10:   uc = '{5'd15, OP_PW1, OP_PW1, 1'b0};
         5'd11:   uc = '{5'd16, OP_PW1, OP_PW0, 1'b1};
         5'd12:   uc = '{5'd17, OP_PW2, OP_PW0, 1'b1};
         5'd13:   uc = '{5'd18, OP_PW2, OP_PW2, 1'b0};
         5'd14:   uc = '{5'd18, OP_PW0, OP_PW0, 1'b0};
         5'd15:   uc = '{5'd19, OP_PW2, OP_PW1, 1'b1};
         5'd16:   uc = '{5'd20, OP_PW1, OP_PW1, 1'b0};
         5'd17:   uc = '{5'd20, OP_PW0, OP_PW0, 1'b0};
         5'd18:   uc = '{5'd21, OP_ONE, OP_R0,  1'b0};
         5'd19:   uc = '{5'd22, OP_ONE, OP_R1,  1'b0};
         5'd20:   uc = '{5'd23, OP_ONE, OP_R2,  1'b0};
         5'd21:   uc = '{5'd24, OP_PW2, OP_R1,  1'b1};
         5'd22:   uc = '{5'd24, OP_PW1, OP_R2,  1'b0};
         5'd23:   uc = '{5'd25, OP_PW2, OP_R0,  1'b0};
         5'd24:   uc = '{5'd25, OP_PW0, OP_R2,  1'b1};
         5'd25:   uc = '{5'd26, OP_PW1, OP_R0,  1'b1};
         5'd26:   uc = '{5'd26, OP_PW0, OP_R1,  1'b0};
         5'd27:   uc = '{5'd27, OP_R0,  OP_R0,  1'b0};
         5'd28:   uc = '{5'd27, OP_R1,  OP_R1,  1'b0};
         5'd29:   uc = '{5'd27, OP_R2,  OP_R2,  1'b0};
         default: uc = '{5'd0,  OP_ONE, OP_ONE, 1'b0};
      endcase
      return uc;
   endfunction

endpackage

FILE: sv/icp_normal_equation_accumulator_core.sv
// icp normal-equation accumulator: pose transform, jacobian products, saturating sums
// The block holds off new points (req_stall) until it is back in idle: the 9 rotation
// products and, for a matched point, the 30 jacobian products all go in turn
// through the single shared multiplier.
// A point marked last then puts out 29 result transfers, one per cycle unless stalled.
// Synchronous reset clears the pose registers, all sums, the count and the sequencer.
module icp_normal_equation_accumulator_core #(
   parameter int ROT_FRAC_BITS = icpne_pkg::ROT_FRAC_BITS_DEF,
   parameter int ACC_BITS      = icpne_pkg::ACC_BITS_DEF,
   parameter int MAX_POINTS    = icpne_pkg::MAX_POINTS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  icpne_pkg::req_payload_type           req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output icpne_pkg::rsp_payload_type           rsp_payload,
   input  logic                                 csr_wen,
   input  logic [icpne_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [icpne_pkg::CSR_W-1:0]          csr_wdata
);
   import icpne_pkg::*;

   localparam int ROT_W = ROT_FRAC_BITS + 2;
   localparam int AW    = (ROT_W > COORD_BITS + 1) ? ROT_W : COORD_BITS + 1;
   localparam int BW    = COORD_BITS + 1;
   localparam int PW    = AW + BW;
   localparam int LW    = (PW > 64) ? PW : 65;
   localparam int SUMW  = 66;
   localparam int SW    = ROT_W + COORD_BITS + 3;
   localparam int RX    = (3 * ROT_W > CSR_W) ? 3 * ROT_W : CSR_W;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ROT   = 3'd1;
   localparam logic [2:0] ST_WAIT  = 3'd2;
   localparam logic [2:0] ST_RES   = 3'd3;
   localparam logic [2:0] ST_ACC   = 3'd4;
   localparam logic [2:0] ST_DRAIN = 3'd5;
   localparam logic [2:0] ST_EMIT  = 3'd6;

   localparam logic signed [LW-1:0]   P_MAX = LW'(64'sh7fff_ffff_ffff_ffff);
   localparam logic signed [LW-1:0]   P_MIN = -P_MAX - LW'(1);
   localparam logic signed [SUMW-1:0] A_MAX = (SUMW'(1) <<< (ACC_BITS - 1)) - SUMW'(1);
   localparam logic signed [SUMW-1:0] A_MIN = -A_MAX - SUMW'(1);
   localparam logic signed [SW-1:0]   RND   = SW'(1) <<< (ROT_FRAC_BITS - 1);
   localparam logic signed [SW-1:0]   C_MAX = (SW'(1) <<< (COORD_BITS - 1)) - SW'(1);
   localparam logic signed [SW-1:0]   C_MIN = -C_MAX - SW'(1);

   // configuration
   logic [CSR_W-1:0]             rot_ff   [3];
   logic signed [COORD_BITS-1:0] shift_ff [3];

   // point and sequencer state
   logic [2:0]                   state_ff, state_in;
   logic [1:0]                   row_ff, row_in, col_ff, col_in;
   logic [IDX_W-1:0]             step_ff, step_in;
   req_payload_type              pt_ff;
   logic signed [COORD_BITS-1:0] pw_ff [3];
   logic signed [BW-1:0]         r_ff  [3];
   logic signed [SW-1:0]         s_ff;

   // multiplier stage
   logic                         mv_ff, mv_in;
   logic                         mrot_ff, mrot_in;
   logic                         mlast_ff, mlast_in;
   logic [1:0]                   mrow_ff, mrow_in;
   logic [IDX_W-1:0]             mdst_ff, mdst_in;
   logic signed [PW-1:0]         prod_ff, prod_in;

   // sums
   logic signed [ACC_BITS-1:0]   acc_ff [ACC_DEPTH];
   logic [CNT_W-1:0]             cnt_ff;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_payload_type              rsp_payload_ff, rsp_payload_in;
   logic                         emit_load;
   logic                         emit_done;

   logic signed [AW-1:0]         mul_a;
   logic signed [BW-1:0]         mul_b;
   logic signed [BW-1:0]         opa, opb;
   ucode_type                    uc;
   logic [RX-1:0]                rot_x;
   logic signed [COORD_BITS-1:0] pcol;

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // operand selection
   function automatic logic signed [BW-1:0] pick(
      input logic [2:0] sel,
      input logic signed [COORD_BITS-1:0] p0, p1, p2,
      input logic signed [BW-1:0] q0, q1, q2
   );
      logic signed [BW-1:0] v;
      case (sel)
         OP_PW0:  v = BW'(p0);
         OP_PW1:  v = BW'(p1);
         OP_PW2:  v = BW'(p2);
         OP_R0:   v = q0;
         OP_R1:   v = q1;
         OP_R2:   v = q2;
         default: v = BW'(1);
      endcase
      return v;
   endfunction

   always_comb begin
      uc    = step_code(step_ff);
      opa   = pick(uc.sel_a, pw_ff[0], pw_ff[1], pw_ff[2], r_ff[0], r_ff[1], r_ff[2]);
      opb   = pick(uc.sel_b, pw_ff[0], pw_ff[1], pw_ff[2], r_ff[0], r_ff[1], r_ff[2]);
      rot_x = RX'(rot_ff[row_ff]);
      case (col_ff)
         2'd0:    pcol = pt_ff.body_x;
         2'd1:    pcol = pt_ff.body_y;
         default: pcol = pt_ff.body_z;
      endcase
      if (state_ff == ST_ROT) begin
         mul_a = AW'($signed(rot_x[col_ff * ROT_W +: ROT_W]));
         mul_b = BW'(pcol);
      end else begin
         mul_a = uc.neg ? -AW'(opa) : AW'(opa);
         mul_b = opb;
      end
      prod_in = PW'(mul_a) * PW'(mul_b);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      step_in  = step_ff;
      mv_in    = 1'b0;
      mrot_in  = (state_ff == ST_ROT);
      mlast_in = (col_ff == 2'd2);
      mrow_in  = row_ff;
      mdst_in  = uc.dst;
      emit_load = 1'b0;
      emit_done = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_ROT;
               row_in   = 2'd0;
               col_in   = 2'd0;
            end
         end
         ST_ROT: begin
            mv_in = 1'b1;
            if (col_ff == 2'd2) begin
               col_in = 2'd0;
               row_in = row_ff + 2'd1;
               if (row_ff == 2'd2) begin
                  state_in = ST_WAIT;
               end
            end else begin
               col_in = col_ff + 2'd1;
            end
         end
         ST_WAIT: begin
            if (pt_ff.neighbor_found) begin
               state_in = ST_RES;
            end else begin
               state_in = pt_ff.last_point ? ST_EMIT : ST_IDLE;
            end
            step_in = '0;
         end
         ST_RES: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            mv_in   = 1'b1;
            step_in = step_ff + IDX_W'(1);
            if (step_ff == IDX_W'(ACC_STEPS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = pt_ff.last_point ? ST_EMIT : ST_IDLE;
            step_in  = '0;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               emit_load = 1'b1;
               step_in   = step_ff + IDX_W'(1);
               if (step_ff == ENTRY_COUNT) begin
                  emit_done = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register next value
   always_comb begin
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (emit_load) begin
         rsp_valid_in               = 1'b1;
         rsp_payload_in.entry_index = step_ff;
         rsp_payload_in.final_entry = (step_ff == ENTRY_COUNT);
         if (step_ff == ENTRY_COUNT) begin
            rsp_payload_in.entry_value = VAL_W'(cnt_ff);
         end else begin
            rsp_payload_in.entry_value = VAL_W'(acc_ff[step_ff]);
         end
      end
   end

   // second stage arithmetic: clamp product, saturating add, pose rounding
   logic signed [LW-1:0]   prod_x;
   logic signed [63:0]     prod_c;
   logic signed [SUMW-1:0] acc_sum;
   logic signed [ACC_BITS-1:0] acc_new;
   logic signed [SW-1:0]   s_sum, s_pos;

   always_comb begin
      prod_x = LW'(prod_ff);
      if (prod_x > P_MAX) begin
         prod_c = 64'(P_MAX);
      end else if (prod_x < P_MIN) begin
         prod_c = 64'(P_MIN);
      end else begin
         prod_c = 64'(prod_x);
      end
      acc_sum = SUMW'(acc_ff[mdst_ff]) + SUMW'(prod_c);
      if (acc_sum > A_MAX) begin
         acc_new = ACC_BITS'(A_MAX);
      end else if (acc_sum < A_MIN) begin
         acc_new = ACC_BITS'(A_MIN);
      end else begin
         acc_new = ACC_BITS'(acc_sum);
      end
      s_sum = s_ff + SW'(prod_ff);
      s_pos = ((s_sum + RND) >>> ROT_FRAC_BITS) + SW'(shift_ff[mrow_ff]);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         step_ff      <= '0;
         mv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         step_ff      <= step_in;
         mv_ff        <= mv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (emit_done) begin
            cnt_ff <= '0;
         end else if (state_ff == ST_RES && cnt_ff < CNT_W'(MAX_POINTS)) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            rot_ff[i]   <= '0;
            shift_ff[i] <= '0;
         end
      end else if (csr_wen) begin
         case (csr_index)
            CSR_ROT0:   rot_ff[0]   <= csr_wdata;
            CSR_ROT1:   rot_ff[1]   <= csr_wdata;
            CSR_ROT2:   rot_ff[2]   <= csr_wdata;
            CSR_SHIFTX: shift_ff[0] <= COORD_BITS'(csr_wdata);
            CSR_SHIFTY: shift_ff[1] <= COORD_BITS'(csr_wdata);
            CSR_SHIFTZ: shift_ff[2] <= COORD_BITS'(csr_wdata);
            default:    ;
         endcase
      end
   end

   // sums: cleared after the final transfer is loaded
   always_ff @(posedge clock) begin
      if (reset || emit_done) begin
         for (int i = 0; i < ACC_DEPTH; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (mv_ff && !mrot_ff) begin
         acc_ff[mdst_ff] <= acc_new;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      mrot_ff        <= mrot_in;
      mlast_ff       <= mlast_in;
      mrow_ff        <= mrow_in;
      mdst_ff        <= mdst_in;
      prod_ff        <= prod_in;
      rsp_payload_ff <= rsp_payload_in;
      if (state_ff == ST_IDLE) begin
         pt_ff <= req_payload;
         s_ff  <= '0;
      end
      if (mv_ff && mrot_ff) begin
         if (mlast_ff) begin
            s_ff <= '0;
            if (s_pos > C_MAX) begin
               pw_ff[mrow_ff] <= COORD_BITS'(C_MAX);
            end else if (s_pos < C_MIN) begin
               pw_ff[mrow_ff] <= COORD_BITS'(C_MIN);
            end else begin
               pw_ff[mrow_ff] <= COORD_BITS'(s_pos);
            end
         end else begin
            s_ff <= s_sum;
         end
      end
      if (state_ff == ST_RES) begin
         r_ff[0] <= BW'(pw_ff[0]) - BW'(pt_ff.nbr_x);
         r_ff[1] <= BW'(pw_ff[1]) - BW'(pt_ff.nbr_y);
         r_ff[2] <= BW'(pw_ff[2]) - BW'(pt_ff.nbr_z);
      end
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_POINTS))
      else $error("match count beyond limit");

   a_final_tag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_payload_ff.final_entry ==
                        (rsp_payload_ff.entry_index == ENTRY_COUNT)))
      else $error("final flag does not match last entry");

   a_mul_in_work: assert property (@(posedge clock) disable iff (reset)
      mv_ff |-> (state_ff == ST_ROT || state_ff == ST_WAIT ||
                 state_ff == ST_ACC || state_ff == ST_DRAIN))
      else $error("product pending outside arithmetic states");

   a_emit_after_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !mv_ff)
      else $error("sums still updating while results go out");

endmodule
